### hdl/pfc_pkg.sv
// Shared constants, types and helpers for the Playfair digram cipher.
package pfc_pkg;

   localparam logic [4:0] LETTER_Z = 5'd25;
   localparam logic [4:0] LETTER_J = 5'd9;
   localparam logic [4:0] LETTER_I = 5'd8;
   localparam logic [3:0] GRID     = 4'd5;
   localparam logic [2:0] SHIFT_ENC = 3'd1;
   localparam logic [2:0] SHIFT_DEC = 3'd4;

   typedef enum logic [1:0] {
      CFG_KEY_LOW  = 2'd0,
      CFG_KEY_MID  = 2'd1,
      CFG_KEY_TOP  = 2'd2,
      CFG_DECRYPT  = 2'd3
   } cfg_index_type;

   typedef struct packed {
      logic [59:0] key_low;
      logic [59:0] key_mid;
      logic [4:0]  key_top;
      logic        decrypt;
   } key_cfg_type;

   function automatic logic [2:0] grid_step(input logic [2:0] pos, input logic [2:0] shift);
      logic [3:0] sum;
      sum = {1'b0, pos} + {1'b0, shift};
      if (sum >= GRID) begin
         sum = sum - GRID;
      end
      return sum[2:0];
   endfunction

endpackage

### hdl/pfc_coder.sv
// Playfair pair coder: locates both letters in the key grid and picks the result letters.
module pfc_coder
   import pfc_pkg::*;
(
   input  key_cfg_type cfg,
   input  logic [4:0]  letter_a,
   input  logic [4:0]  letter_b,
   output logic [6:0]  char_a,
   output logic [6:0]  char_b
);

   logic [4:0]   grid [5][5];
   logic [124:0] flat;
   logic [2:0]   row_a, col_a, row_b, col_b;
   logic [2:0]   shift;
   logic [4:0]   cell_a, cell_b;

   assign flat  = {cfg.key_top, cfg.key_mid, cfg.key_low};
   assign shift = cfg.decrypt ? SHIFT_DEC : SHIFT_ENC;

   always_comb begin
      row_a = 3'd0;
      col_a = 3'd0;
      row_b = 3'd0;
      col_b = 3'd0;
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            grid[r][c] = flat[5*(r*5+c) +: 5];
            // highest matching cell wins
            if (grid[r][c] == letter_a) begin
               row_a = 3'(r);
               col_a = 3'(c);
            end
            if (grid[r][c] == letter_b) begin
               row_b = 3'(r);
               col_b = 3'(c);
            end
         end
      end
   end

   always_comb begin
      if (row_a == row_b) begin
         cell_a = grid[row_a][grid_step(col_a, shift)];
         cell_b = grid[row_b][grid_step(col_b, shift)];
      end else if (col_a == col_b) begin
         cell_a = grid[grid_step(row_a, shift)][col_a];
         cell_b = grid[grid_step(row_b, shift)][col_b];
      end else begin
         cell_a = grid[row_a][col_b];
         cell_b = grid[row_b][col_a];
      end
   end

   assign char_a = 7'd97 + {2'b00, cell_a};
   assign char_b = 7'd97 + {2'b00, cell_b};

endmodule

### hdl/playfair_digram_cipher.sv
// Top level of the Playfair digram cipher stream block.
//
// Characters enter one per beat with tlast on the final one of a message. Letters are
// folded to lower case, 'j' is read as 'i', everything else is dropped. Each completed
// pair gives two result beats; an odd final letter is padded with 'z'. A character is
// accepted every cycle while the pair register can move on; since a pair takes two
// output beats, the output port (one beat per cycle) sets the sustained rate at one
// character per cycle. A completing character passes the pair and output registers
// before its first result beat. The 5x5 key table and the mode are loaded through the
// csr port; the user must do so only while idle, as the block does not enforce it.
module playfair_digram_cipher
   import pfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [59:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] out_char, [7] zero
   output logic        rsp_tlast    // out_last
);

   key_cfg_type cfg_ff;

   logic [4:0] held_ff, held_in;
   logic       has_held_ff, has_held_in;

   logic       pair_valid_ff;
   logic [4:0] pair_a_ff, pair_b_ff;
   logic       pair_last_ff;
   logic       pair_load;
   logic [4:0] pair_a_in, pair_b_in;

   logic       out_valid_ff, out_second_ff, out_last_ff;
   logic [6:0] out_a_ff, out_b_ff;
   logic [6:0] code_a, code_b;

   logic       req_beat, rsp_beat, out_free, pair_move;
   logic [7:0] ch;
   logic       is_letter;
   logic [4:0] idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (cfg_index_type'(csr_index))
            CFG_KEY_LOW: cfg_ff.key_low <= csr_wdata;
            CFG_KEY_MID: cfg_ff.key_mid <= csr_wdata;
            CFG_KEY_TOP: cfg_ff.key_top <= csr_wdata[4:0];
            CFG_DECRYPT: cfg_ff.decrypt <= csr_wdata[0];
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign out_free   = !out_valid_ff || (out_second_ff && rsp_tready);
   assign pair_move  = pair_valid_ff && out_free;
   assign req_tready = !pair_valid_ff || pair_move;
   assign req_beat   = req_tvalid && req_tready;

   // fold case and map j onto i
   always_comb begin
      ch = req_tdata;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         ch = ch + 8'd32;
      end
      is_letter = (ch >= 8'd97) && (ch <= 8'd122);
      idx = 5'(ch - 8'd97);
      if (!is_letter) begin
         idx = 5'd0;
      end else if (idx == LETTER_J) begin
         idx = LETTER_I;
      end
   end

   always_comb begin
      held_in     = held_ff;
      has_held_in = has_held_ff;
      pair_load   = 1'b0;
      pair_a_in   = held_ff;
      pair_b_in   = idx;
      if (is_letter) begin
         if (has_held_ff) begin
            pair_load   = 1'b1;
            has_held_in = 1'b0;
         end else if (req_tlast) begin
            pair_load = 1'b1;
            pair_a_in = idx;
            pair_b_in = LETTER_Z;
         end else begin
            held_in     = idx;
            has_held_in = 1'b1;
         end
      end else if (req_tlast && has_held_ff) begin
         pair_load   = 1'b1;
         pair_b_in   = LETTER_Z;
         has_held_in = 1'b0;
      end
      if (req_tlast) begin
         has_held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_held_ff   <= 1'b0;
         held_ff       <= '0;
         pair_valid_ff <= 1'b0;
      end else begin
         if (req_beat) begin
            has_held_ff <= has_held_in;
            held_ff     <= held_in;
         end
         if (req_beat && pair_load) begin
            pair_valid_ff <= 1'b1;
         end else if (pair_move) begin
            pair_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && pair_load) begin
         pair_a_ff    <= pair_a_in;
         pair_b_ff    <= pair_b_in;
         pair_last_ff <= req_tlast;
      end
   end

   pfc_coder u_coder (
      .cfg      (cfg_ff),
      .letter_a (pair_a_ff),
      .letter_b (pair_b_ff),
      .char_a   (code_a),
      .char_b   (code_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         out_second_ff <= 1'b0;
      end else if (pair_move) begin
         out_valid_ff  <= 1'b1;
         out_second_ff <= 1'b0;
      end else if (rsp_beat) begin
         if (out_second_ff) begin
            out_valid_ff  <= 1'b0;
            out_second_ff <= 1'b0;
         end else begin
            out_second_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pair_move) begin
         out_a_ff    <= code_a;
         out_b_ff    <= code_b;
         out_last_ff <= pair_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_second_ff ? out_b_ff : out_a_ff};
   assign rsp_tlast  = out_second_ff && out_last_ff;

endmodule
